@@ rtl/core/afc_pkg.sv @@
// ----------------------------------------------------------------------------
// afc_pkg
// Shared constants, codes and types of the box against frustum classifier.
// ----------------------------------------------------------------------------
package afc_pkg;

    localparam int COORD_W       = 32;
    localparam int ACC_W         = 66;
    localparam int FRAC_BITS_DEF = 16;
    localparam int NUM_PLANES    = 6;
    localparam int NUM_CORNERS   = 8;
    localparam int PLANE_WORDS   = 4;
    localparam int CORNER_WORDS  = 3;
    localparam int MEM_DEPTH     = 24;
    localparam int MEM_ADDR_W    = $clog2(MEM_DEPTH);

    localparam logic [2:0] AXIS_ALL = 3'h7;

    // Request opcodes; the fourth code is ignored.
    localparam logic [1:0] OP_LOAD_PLANE  = 2'd0;
    localparam logic [1:0] OP_LOAD_CORNER = 2'd1;
    localparam logic [1:0] OP_CLASSIFY    = 2'd2;

    // Verdict codes.
    localparam logic [1:0] VERDICT_OUTSIDE   = 2'd0;
    localparam logic [1:0] VERDICT_INTERSECT = 2'd1;
    localparam logic [1:0] VERDICT_INSIDE    = 2'd2;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [ACC_W-1:0]   acc_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD_PLANE,
        ST_LOAD_CORNER,
        ST_CORNERS,
        ST_PLANES,
        ST_FINISH
    } state_t;

endpackage

@@ rtl/core/afc_ram.sv @@
// ----------------------------------------------------------------------------
// afc_ram
// Generic single write port, single read port RAM with a registered read.
// ----------------------------------------------------------------------------
module afc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 24
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/core/aabb_frustum_classify.sv @@
// ----------------------------------------------------------------------------
// aabb_frustum_classify
// Classifies axis-aligned boxes against a stored frustum of six planes and
// eight corners, each held word by word in a small RAM.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                                        Handshake
//  --------  -------------------------------------------  ------------------
//  request   opcode slot x_lo y_lo z_lo x_hi y_hi z_hi     start && !busy
//            plane_offset
//  result    verdict containing_planes                    done, one cycle
//
// A plane load keeps busy high while its four words are written, a corner load
// while its three are, one RAM write per stored word. A classify keeps busy
// high while 24 corner words and then 24 plane words are read, one word per
// cycle through the single read port of each RAM, and then until the multiply
// and accumulate pipeline is empty. The result strobe appears in the same
// cycle that busy falls, so a new request may be accepted while it is shown.
// Reset clears the control state and the per-word valid bits, so unwritten
// words read as zero. The receiver cannot stall; each result is shown for
// exactly one cycle.
module aabb_frustum_classify #(
    parameter int FRAC_BITS = afc_pkg::FRAC_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           opcode,
    input  logic [2:0]           slot,
    input  logic signed [31:0]   x_lo,
    input  logic signed [31:0]   y_lo,
    input  logic signed [31:0]   z_lo,
    input  logic signed [31:0]   x_hi,
    input  logic signed [31:0]   y_hi,
    input  logic signed [31:0]   z_hi,
    input  logic signed [31:0]   plane_offset,
    output logic                 done,
    output logic [1:0]           verdict,
    output logic [2:0]           containing_planes
);

    localparam int AW = afc_pkg::MEM_ADDR_W;
    localparam int PW = 2 * afc_pkg::COORD_W;

    afc_pkg::state_t state_reg, state_next;
    logic [AW-1:0]   idx_reg, idx_next;
    logic [1:0]      k_reg, k_next;

    // Request payload
    logic [2:0]      slot_reg;
    afc_pkg::coord_t lo_reg [3];
    afc_pkg::coord_t hi_reg [3];
    afc_pkg::coord_t offset_reg;

    // Memory interface
    logic            plane_we, corner_we;
    logic [AW-1:0]   waddr;
    afc_pkg::coord_t wdata;
    logic [AW-1:0]   raddr;
    afc_pkg::coord_t plane_rdata, corner_rdata;
    logic [afc_pkg::MEM_DEPTH-1:0] plane_vld_reg, plane_vld_next;
    logic [afc_pkg::MEM_DEPTH-1:0] corner_vld_reg, corner_vld_next;

    // Read stage
    logic            s1_vld_reg, s1_vld_next;
    logic            s1_plane_reg, s1_plane_next;
    logic [1:0]      s1_k_reg, s1_k_next;
    logic            s1_mem_vld_reg, s1_mem_vld_next;

    // Product stage
    logic            s2_vld_reg, s2_vld_next;
    logic            s2_last_reg, s2_last_next;
    afc_pkg::acc_t   p_far_reg, p_far_next;
    afc_pkg::acc_t   p_near_reg, p_near_next;

    // Accumulation and verdict state
    afc_pkg::acc_t   acc_far_reg, acc_far_next;
    afc_pkg::acc_t   acc_near_reg, acc_near_next;
    logic [2:0]      count_reg, count_next;
    logic            fail_reg, fail_next;
    logic [2:0]      above_reg, above_next;
    logic [2:0]      below_reg, below_next;

    logic            done_reg, done_next;
    logic [1:0]      verdict_reg, verdict_next;
    logic [2:0]      planes_reg, planes_next;

    logic            accept;
    logic            pipe_empty;

    afc_pkg::coord_t coef, corner;
    afc_pkg::coord_t box_lo, box_hi, far_op, near_op;
    logic signed [PW-1:0] mul_far, mul_near;
    afc_pkg::acc_t   sum_far, sum_near;

    assign busy       = (state_reg != afc_pkg::ST_IDLE);
    assign accept     = start && !busy;
    assign pipe_empty = !s1_vld_reg && !s2_vld_reg;

    afc_ram #(
        .WIDTH (afc_pkg::COORD_W),
        .DEPTH (afc_pkg::MEM_DEPTH)
    ) u_plane_ram (
        .clk   (clk),
        .we    (plane_we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (plane_rdata)
    );

    afc_ram #(
        .WIDTH (afc_pkg::COORD_W),
        .DEPTH (afc_pkg::MEM_DEPTH)
    ) u_corner_ram (
        .clk   (clk),
        .we    (corner_we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (corner_rdata)
    );

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        k_next     = k_reg;
        unique case (state_reg)
            afc_pkg::ST_IDLE:
            begin
                idx_next = '0;
                k_next   = '0;
                if (start)
                begin
                    priority if (opcode == afc_pkg::OP_LOAD_PLANE
                                 && slot < 3'(afc_pkg::NUM_PLANES))
                    begin
                        state_next = afc_pkg::ST_LOAD_PLANE;
                    end
                    else if (opcode == afc_pkg::OP_LOAD_CORNER)
                    begin
                        state_next = afc_pkg::ST_LOAD_CORNER;
                    end
                    else if (opcode == afc_pkg::OP_CLASSIFY)
                    begin
                        state_next = afc_pkg::ST_CORNERS;
                    end
                    else
                    begin
                        state_next = afc_pkg::ST_IDLE;
                    end
                end
            end
            afc_pkg::ST_LOAD_PLANE:
            begin
                idx_next = idx_reg + AW'(1);
                if (idx_reg == AW'(afc_pkg::PLANE_WORDS - 1))
                begin
                    state_next = afc_pkg::ST_IDLE;
                end
            end
            afc_pkg::ST_LOAD_CORNER:
            begin
                idx_next = idx_reg + AW'(1);
                if (idx_reg == AW'(afc_pkg::CORNER_WORDS - 1))
                begin
                    state_next = afc_pkg::ST_IDLE;
                end
            end
            afc_pkg::ST_CORNERS:
            begin
                idx_next = idx_reg + AW'(1);
                k_next   = (k_reg == 2'(afc_pkg::CORNER_WORDS - 1)) ? 2'd0 : k_reg + 2'd1;
                if (idx_reg == AW'(afc_pkg::MEM_DEPTH - 1))
                begin
                    idx_next   = '0;
                    state_next = afc_pkg::ST_PLANES;
                end
            end
            afc_pkg::ST_PLANES:
            begin
                idx_next = idx_reg + AW'(1);
                if (idx_reg == AW'(afc_pkg::MEM_DEPTH - 1))
                begin
                    state_next = afc_pkg::ST_FINISH;
                end
            end
            afc_pkg::ST_FINISH:
            begin
                if (pipe_empty)
                begin
                    state_next = afc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = afc_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: memory controls and read issue
    // ------------------------------------------------------------------
    always_comb
    begin
        plane_we      = 1'b0;
        corner_we     = 1'b0;
        waddr         = '0;
        wdata         = lo_reg[0];
        raddr         = idx_reg;
        s1_vld_next   = 1'b0;
        s1_plane_next = 1'b0;
        s1_k_next     = k_reg;
        unique case (state_reg)
            afc_pkg::ST_LOAD_PLANE:
            begin
                plane_we = 1'b1;
                waddr    = AW'({slot_reg, 2'b00}) + idx_reg;
                unique case (idx_reg[1:0])
                    2'd0:    wdata = lo_reg[0];
                    2'd1:    wdata = lo_reg[1];
                    2'd2:    wdata = lo_reg[2];
                    default: wdata = offset_reg;
                endcase
            end
            afc_pkg::ST_LOAD_CORNER:
            begin
                corner_we = 1'b1;
                waddr     = AW'({slot_reg, 1'b0}) + AW'(slot_reg) + idx_reg;
                unique case (idx_reg[1:0])
                    2'd0:    wdata = lo_reg[0];
                    2'd1:    wdata = lo_reg[1];
                    default: wdata = lo_reg[2];
                endcase
            end
            afc_pkg::ST_CORNERS:
            begin
                s1_vld_next = 1'b1;
            end
            afc_pkg::ST_PLANES:
            begin
                s1_vld_next   = 1'b1;
                s1_plane_next = 1'b1;
                s1_k_next     = idx_reg[1:0];
            end
            default:
            begin
                s1_vld_next = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        plane_vld_next  = plane_vld_reg;
        corner_vld_next = corner_vld_reg;
        if (plane_we)
        begin
            plane_vld_next[waddr] = 1'b1;
        end
        if (corner_we)
        begin
            corner_vld_next[waddr] = 1'b1;
        end
        s1_mem_vld_next = s1_plane_next ? plane_vld_reg[raddr] : corner_vld_reg[raddr];
    end

    // ------------------------------------------------------------------
    // Read stage: corner compare, plane products
    // ------------------------------------------------------------------
    always_comb
    begin
        coef   = s1_mem_vld_reg ? plane_rdata  : '0;
        corner = s1_mem_vld_reg ? corner_rdata : '0;
        unique case (s1_k_reg)
            2'd0:
            begin
                box_lo = lo_reg[0];
                box_hi = hi_reg[0];
            end
            2'd1:
            begin
                box_lo = lo_reg[1];
                box_hi = hi_reg[1];
            end
            default:
            begin
                box_lo = lo_reg[2];
                box_hi = hi_reg[2];
            end
        endcase
        // A negative normal component turns the box around on that axis.
        far_op   = coef[afc_pkg::COORD_W-1] ? box_lo : box_hi;
        near_op  = coef[afc_pkg::COORD_W-1] ? box_hi : box_lo;
        mul_far  = PW'(coef) * PW'(far_op);
        mul_near = PW'(coef) * PW'(near_op);

        s2_vld_next  = s1_vld_reg && s1_plane_reg;
        s2_last_next = (s1_k_reg == 2'(afc_pkg::PLANE_WORDS - 1));
        if (s2_last_next)
        begin
            p_far_next  = afc_pkg::acc_t'(coef) <<< FRAC_BITS;
            p_near_next = p_far_next;
        end
        else
        begin
            p_far_next  = afc_pkg::acc_t'(mul_far);
            p_near_next = afc_pkg::acc_t'(mul_near);
        end
    end

    // ------------------------------------------------------------------
    // Accumulate and verdict
    // ------------------------------------------------------------------
    always_comb
    begin
        above_next    = above_reg;
        below_next    = below_reg;
        acc_far_next  = acc_far_reg;
        acc_near_next = acc_near_reg;
        count_next    = count_reg;
        fail_next     = fail_reg;
        sum_far       = acc_far_reg + p_far_reg;
        sum_near      = acc_near_reg + p_near_reg;
        done_next     = 1'b0;
        verdict_next  = verdict_reg;
        planes_next   = planes_reg;

        if (accept)
        begin
            above_next    = afc_pkg::AXIS_ALL;
            below_next    = afc_pkg::AXIS_ALL;
            acc_far_next  = '0;
            acc_near_next = '0;
            count_next    = '0;
            fail_next     = 1'b0;
        end

        if (s1_vld_reg && !s1_plane_reg)
        begin
            if (!(corner > box_hi))
            begin
                above_next = above_next & ~(3'b001 << s1_k_reg);
            end
            if (!(corner < box_lo))
            begin
                below_next = below_next & ~(3'b001 << s1_k_reg);
            end
        end

        if (s2_vld_reg)
        begin
            if (s2_last_reg)
            begin
                acc_far_next  = '0;
                acc_near_next = '0;
                if (sum_far[afc_pkg::ACC_W-1])
                begin
                    fail_next = 1'b1;
                end
                if (!sum_near[afc_pkg::ACC_W-1])
                begin
                    count_next = count_reg + 3'd1;
                end
            end
            else
            begin
                acc_far_next  = sum_far;
                acc_near_next = sum_near;
            end
        end

        if (state_reg == afc_pkg::ST_FINISH && pipe_empty)
        begin
            done_next = 1'b1;
            if (fail_reg || ((above_reg | below_reg) != 3'b000))
            begin
                verdict_next = afc_pkg::VERDICT_OUTSIDE;
                planes_next  = '0;
            end
            else
            begin
                verdict_next = (count_reg == 3'(afc_pkg::NUM_PLANES))
                             ? afc_pkg::VERDICT_INSIDE : afc_pkg::VERDICT_INTERSECT;
                planes_next  = count_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= afc_pkg::ST_IDLE;
            idx_reg        <= '0;
            k_reg          <= '0;
            plane_vld_reg  <= '0;
            corner_vld_reg <= '0;
            s1_vld_reg     <= 1'b0;
            s2_vld_reg     <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            k_reg          <= k_next;
            plane_vld_reg  <= plane_vld_next;
            corner_vld_reg <= corner_vld_next;
            s1_vld_reg     <= s1_vld_next;
            s2_vld_reg     <= s2_vld_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            slot_reg   <= slot;
            lo_reg[0]  <= x_lo;
            lo_reg[1]  <= y_lo;
            lo_reg[2]  <= z_lo;
            hi_reg[0]  <= x_hi;
            hi_reg[1]  <= y_hi;
            hi_reg[2]  <= z_hi;
            offset_reg <= plane_offset;
        end
        s1_plane_reg   <= s1_plane_next;
        s1_k_reg       <= s1_k_next;
        s1_mem_vld_reg <= s1_mem_vld_next;
        s2_last_reg    <= s2_last_next;
        p_far_reg      <= p_far_next;
        p_near_reg     <= p_near_next;
        acc_far_reg    <= acc_far_next;
        acc_near_reg   <= acc_near_next;
        count_reg      <= count_next;
        fail_reg       <= fail_next;
        above_reg      <= above_next;
        below_reg      <= below_next;
        verdict_reg    <= verdict_next;
        planes_reg     <= planes_next;
    end

    assign done              = done_reg;
    assign verdict           = verdict_reg;
    assign containing_planes = planes_reg;

endmodule

@@ tb/sv/tb_aabb_frustum_classify.sv @@
// ----------------------------------------------------------------------------
// tb_aabb_frustum_classify
// Self-checking bench for the box against frustum classifier. Requests are
// queued up front and driven one at a time over the start/busy handshake.
// Each accepted request is applied to a local copy of the stored planes and
// corners, and each classify request queues its predicted verdict. Every
// result strobe is checked against the oldest queued verdict.
// ----------------------------------------------------------------------------
module tb_aabb_frustum_classify;
    import afc_pkg::*;

    localparam int         FRAC         = FRAC_BITS_DEF;
    localparam int         TARGET_ITEMS = 600;
    localparam int         QUIET_FROM   = 250;
    localparam int         QUIET_TO     = 400;
    localparam int         DRAIN_CYCLES = 64;
    localparam logic [1:0] OP_UNUSED    = 2'd3;
    localparam coord_t     ONE          = 32'sd1 <<< FRAC;
    localparam coord_t     HALF         = ONE >>> 1;
    localparam coord_t     C_MIN        = {1'b1, {31{1'b0}}};
    localparam coord_t     C_MAX        = {1'b0, {31{1'b1}}};

    typedef struct packed {
        logic [1:0] op;
        logic [2:0] slot;
        coord_t     x_lo;
        coord_t     y_lo;
        coord_t     z_lo;
        coord_t     x_hi;
        coord_t     y_hi;
        coord_t     z_hi;
        coord_t     offset;
    } request_t;

    typedef struct packed {
        logic [1:0] verdict;
        logic [2:0] planes;
    } outcome_t;

    logic       clk   = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    logic       done;
    logic [1:0] opcode = '0;
    logic [2:0] slot   = '0;
    coord_t     x_lo   = '0;
    coord_t     y_lo   = '0;
    coord_t     z_lo   = '0;
    coord_t     x_hi   = '0;
    coord_t     y_hi   = '0;
    coord_t     z_hi   = '0;
    coord_t     plane_offset = '0;
    logic [1:0] verdict;
    logic [2:0] containing_planes;

    // Local copy of the stored frustum.
    coord_t   plane_words  [MEM_DEPTH];
    coord_t   corner_words [MEM_DEPTH];

    request_t pending_requests [$];
    outcome_t expected_outcomes [$];
    request_t current;
    outcome_t want;
    int       errors   = 0;
    int       accepted = 0;
    bit       quiet;

    // Frustum bounds of the current stimulus phase, per axis.
    int       bound_lo [3];
    int       bound_hi [3];

    aabb_frustum_classify #(
        .FRAC_BITS (FRAC)
    ) uut (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .opcode            (opcode),
        .slot              (slot),
        .x_lo              (x_lo),
        .y_lo              (y_lo),
        .z_lo              (z_lo),
        .x_hi              (x_hi),
        .y_hi              (y_hi),
        .z_hi              (z_hi),
        .plane_offset      (plane_offset),
        .done              (done),
        .verdict           (verdict),
        .containing_planes (containing_planes)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Sign of n.p + w, formed exactly with twice the fraction bits.
    function automatic bit plane_holds(int p, coord_t px, coord_t py, coord_t pz);
        acc_t sum;
        sum = acc_t'(plane_words[PLANE_WORDS*p])     * acc_t'(px)
            + acc_t'(plane_words[PLANE_WORDS*p + 1]) * acc_t'(py)
            + acc_t'(plane_words[PLANE_WORDS*p + 2]) * acc_t'(pz)
            + (acc_t'(plane_words[PLANE_WORDS*p + 3]) <<< FRAC);
        return !sum[ACC_W-1];
    endfunction

    function automatic outcome_t classify_box(request_t r);
        coord_t     lo [3];
        coord_t     hi [3];
        coord_t     far_pt [3];
        coord_t     near_pt [3];
        coord_t     c;
        logic [2:0] above;
        logic [2:0] below;
        int         count;
        int         i;
        int         k;
        outcome_t   res;
        lo[0] = r.x_lo;
        lo[1] = r.y_lo;
        lo[2] = r.z_lo;
        hi[0] = r.x_hi;
        hi[1] = r.y_hi;
        hi[2] = r.z_hi;
        above = AXIS_ALL;
        below = AXIS_ALL;
        count = 0;
        res.verdict = VERDICT_OUTSIDE;
        res.planes  = '0;
        for (i = 0; i < NUM_CORNERS; i++)
        begin
            for (k = 0; k < 3; k++)
            begin
                c = corner_words[CORNER_WORDS*i + k];
                if (!(c > hi[k]))
                    above[k] = 1'b0;
                if (!(c < lo[k]))
                    below[k] = 1'b0;
            end
        end
        if ((above | below) != '0)
            return res;
        for (i = 0; i < NUM_PLANES; i++)
        begin
            for (k = 0; k < 3; k++)
            begin
                // A zero normal component takes the upper bound as the far side.
                if (plane_words[PLANE_WORDS*i + k] < 0)
                begin
                    far_pt[k]  = lo[k];
                    near_pt[k] = hi[k];
                end
                else
                begin
                    far_pt[k]  = hi[k];
                    near_pt[k] = lo[k];
                end
            end
            if (!plane_holds(i, far_pt[0], far_pt[1], far_pt[2]))
                return res;
            if (plane_holds(i, near_pt[0], near_pt[1], near_pt[2]))
                count++;
        end
        res.verdict = (count == NUM_PLANES) ? VERDICT_INSIDE : VERDICT_INTERSECT;
        res.planes  = count[2:0];
        return res;
    endfunction

    function automatic void apply_request(request_t r);
        case (r.op)
            OP_LOAD_PLANE:
                if (r.slot < NUM_PLANES)
                begin
                    plane_words[PLANE_WORDS*r.slot]     = r.x_lo;
                    plane_words[PLANE_WORDS*r.slot + 1] = r.y_lo;
                    plane_words[PLANE_WORDS*r.slot + 2] = r.z_lo;
                    plane_words[PLANE_WORDS*r.slot + 3] = r.offset;
                end
            OP_LOAD_CORNER:
            begin
                corner_words[CORNER_WORDS*r.slot]     = r.x_lo;
                corner_words[CORNER_WORDS*r.slot + 1] = r.y_lo;
                corner_words[CORNER_WORDS*r.slot + 2] = r.z_lo;
            end
            OP_CLASSIFY:
                expected_outcomes.push_back(classify_box(r));
            default:
                ;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic coord_t any_coord();
        return coord_t'($urandom);
    endfunction

    function automatic request_t random_request();
        request_t r;
        r = request_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom});
        return r;
    endfunction

    function automatic void push_request(logic [1:0] op, logic [2:0] sl,
                                         coord_t xl, coord_t yl, coord_t zl,
                                         coord_t xh, coord_t yh, coord_t zh, coord_t w);
        request_t r;
        r.op     = op;
        r.slot   = sl;
        r.x_lo   = xl;
        r.y_lo   = yl;
        r.z_lo   = zl;
        r.x_hi   = xh;
        r.y_hi   = yh;
        r.z_hi   = zh;
        r.offset = w;
        pending_requests.push_back(r);
    endfunction

    function automatic void push_plane(logic [2:0] sl, coord_t nx, coord_t ny, coord_t nz,
                                       coord_t w);
        push_request(OP_LOAD_PLANE, sl, nx, ny, nz, any_coord(), any_coord(), any_coord(), w);
    endfunction

    function automatic void push_box(coord_t xl, coord_t yl, coord_t zl,
                                     coord_t xh, coord_t yh, coord_t zh);
        push_request(OP_CLASSIFY, 3'($urandom), xl, yl, zl, xh, yh, zh, any_coord());
    endfunction

    // Loads a box-shaped frustum from the current bounds, with the normals
    // optionally tipped by up to tilt in each component.
    function automatic void push_box_frustum(int tilt);
        coord_t n [3];
        int     k;
        int     j;
        int     side;
        for (k = 0; k < 3; k++)
        begin
            for (side = 0; side < 2; side++)
            begin
                for (j = 0; j < 3; j++)
                    n[j] = coord_t'($urandom_range(2*tilt)) - tilt;
                n[k] = n[k] + ((side == 0) ? ONE : -ONE);
                push_plane(3'(2*k + side), n[0], n[1], n[2],
                           (side == 0) ? -bound_lo[k] : bound_hi[k]);
            end
        end
        for (k = 0; k < NUM_CORNERS; k++)
            push_request(OP_LOAD_CORNER, 3'(k),
                         k[0] ? bound_hi[0] : bound_lo[0],
                         k[1] ? bound_hi[1] : bound_lo[1],
                         k[2] ? bound_hi[2] : bound_lo[2],
                         any_coord(), any_coord(), any_coord(), any_coord());
    endfunction

    // A box placed against the current bounds, axis by axis: inside, exactly
    // fitting, straddling either face, or clear of them; at times wholly random.
    function automatic void push_random_box();
        coord_t lo [3];
        coord_t hi [3];
        coord_t t;
        int     span;
        int     kind;
        int     k;
        if ($urandom_range(9) == 0)
        begin
            push_box(any_coord(), any_coord(), any_coord(),
                     any_coord(), any_coord(), any_coord());
            return;
        end
        for (k = 0; k < 3; k++)
        begin
            span = bound_hi[k] - bound_lo[k];
            kind = $urandom_range(9);
            if (kind < 5)
            begin
                lo[k] = bound_lo[k] + $urandom_range(span / 2);
                hi[k] = lo[k] + $urandom_range(span / 2);
            end
            else if (kind == 5)
            begin
                lo[k] = bound_lo[k];
                hi[k] = bound_hi[k];
            end
            else if (kind == 6)
            begin
                lo[k] = bound_lo[k] - $urandom_range(span);
                hi[k] = bound_lo[k] + $urandom_range(span);
            end
            else if (kind == 7)
            begin
                lo[k] = bound_hi[k] - $urandom_range(span);
                hi[k] = bound_hi[k] + $urandom_range(span);
            end
            else if (kind == 8)
            begin
                lo[k] = bound_hi[k] + 1 + $urandom_range(span);
                hi[k] = lo[k] + $urandom_range(span);
            end
            else
            begin
                hi[k] = bound_lo[k] - 1 - $urandom_range(span);
                lo[k] = hi[k] - $urandom_range(span);
            end
            // Now and then the bounds arrive the wrong way round.
            if ($urandom_range(19) == 0)
            begin
                t     = lo[k];
                lo[k] = hi[k];
                hi[k] = t;
            end
        end
        push_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
    endfunction

    // ------------------------------------------------------------------------
    // Driver and monitor
    // ------------------------------------------------------------------------

    task automatic drive_request(request_t r, logic strobe);
        start        <= strobe;
        opcode       <= r.op;
        slot         <= r.slot;
        x_lo         <= r.x_lo;
        y_lo         <= r.y_lo;
        z_lo         <= r.z_lo;
        x_hi         <= r.x_hi;
        y_hi         <= r.y_hi;
        z_hi         <= r.z_hi;
        plane_offset <= r.offset;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drive_request('0, 1'b0);
        end
        else
        begin
            if (start && !busy)
            begin
                apply_request(current);
                accepted++;
            end
            // A request still waiting on busy is held as it is.
            if (!start || !busy)
            begin
                quiet = (accepted >= QUIET_FROM) && (accepted < QUIET_TO);
                if (pending_requests.size() != 0 && (quiet || $urandom_range(99) >= 16))
                begin
                    current = pending_requests.pop_front();
                    drive_request(current, 1'b1);
                end
                else
                begin
                    drive_request(random_request(), 1'b0);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_outcomes.size() == 0)
            begin
                $display("%0t: result with none expected: verdict %0d, containing_planes %0d",
                         $time, verdict, containing_planes);
                errors++;
            end
            else
            begin
                want = expected_outcomes.pop_front();
                if (verdict !== want.verdict)
                begin
                    $display("%0t: verdict expected %0d, actual %0d",
                             $time, want.verdict, verdict);
                    errors++;
                end
                if (containing_planes !== want.planes)
                begin
                    $display("%0t: containing_planes expected %0d, actual %0d",
                             $time, want.planes, containing_planes);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------

    initial
    begin
        request_t r;
        int       kind;
        int       k;
        for (k = 0; k < MEM_DEPTH; k++)
        begin
            plane_words[k]  = '0;
            corner_words[k] = '0;
        end

        // With nothing loaded every word is zero: a box touching the origin is
        // inside, one clear of it is outside.
        push_box('0, '0, '0, '0, '0, '0);
        push_box(ONE, ONE, ONE, 2*ONE, 2*ONE, 2*ONE);
        push_box(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX);

        // Requests that must leave the stored frustum untouched.
        r    = random_request();
        r.op = OP_UNUSED;
        pending_requests.push_back(r);
        push_plane(3'd6, ONE, ONE, ONE, -ONE);
        push_plane(3'd7, -ONE, -ONE, -ONE, -ONE);
        push_box('0, '0, '0, '0, '0, '0);

        // Unit cube frustum with exact axis normals.
        for (k = 0; k < 3; k++)
        begin
            bound_lo[k] = -ONE;
            bound_hi[k] = ONE;
        end
        push_box_frustum(0);
        push_box(-HALF, -HALF, -HALF, HALF, HALF, HALF);
        push_box('0, '0, '0, 2*ONE, HALF, HALF);
        push_box(HALF, HALF, HALF, -HALF, -HALF, -HALF);

        // Extreme plane coefficients against an extreme box.
        push_plane(3'd5, C_MIN, C_MAX, '0, C_MIN);
        push_box(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX);

        while (pending_requests.size() < TARGET_ITEMS)
        begin
            kind = $urandom_range(9);
            if (kind < 7)
            begin
                for (k = 0; k < 3; k++)
                begin
                    bound_lo[k] = int'($urandom_range(1 << 25)) - (1 << 24);
                    bound_hi[k] = bound_lo[k] + int'($urandom_range(1 << 24, 1 << 12));
                end
                push_box_frustum(($urandom_range(2) == 0) ? 0 : int'($urandom_range(1 << 13)));
                repeat ($urandom_range(12, 4))
                    push_random_box();
            end
            else if (kind < 9)
            begin
                // Overwrite a few stored words with arbitrary values.
                repeat ($urandom_range(3, 1))
                begin
                    r    = random_request();
                    r.op = ($urandom_range(1) == 0) ? OP_LOAD_PLANE : OP_LOAD_CORNER;
                    pending_requests.push_back(r);
                end
                repeat (2)
                    push_random_box();
            end
            else
            begin
                repeat ($urandom_range(4, 1))
                    pending_requests.push_back(random_request());
            end
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_requests.size() != 0 || start)
            @(posedge clk);
        while (expected_outcomes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0 && expected_outcomes.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
